/* design/amd_pkg.sv */
// Package for the agent message deframer: phase encoding, part labels,
// configuration register indexes and their reset values.
// No dependencies; the core, amd_out_if and amd_cfg_if use it.
package amd_pkg;

    // Message phase, one-hot.
    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_IDLEN   = 6'b000010,
        PH_IDENT   = 6'b000100,
        PH_PLEN    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_BUNDLE  = 6'b100000
    } phase_t;

    // Labels carried on the part field of a result.
    typedef logic [2:0] part_t;
    localparam part_t PART_HEADER  = 3'd0;
    localparam part_t PART_IDLEN   = 3'd1;
    localparam part_t PART_IDENT   = 3'd2;
    localparam part_t PART_PLEN    = 3'd3;
    localparam part_t PART_PAYLOAD = 3'd4;
    localparam part_t PART_BUNDLE  = 3'd5;
    localparam part_t PART_ERROR   = 3'd6;

    // Configuration register indexes.
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_EXPECTED_VERSION   = 3'd0;
    localparam cfg_index_t CFG_HIGHEST_KNOWN_TYPE = 3'd1;
    localparam cfg_index_t CFG_IDENT_TYPE_MASK    = 3'd2;
    localparam cfg_index_t CFG_PAYLOAD_TYPE_MASK  = 3'd3;
    localparam cfg_index_t CFG_BUNDLE_TYPE_MASK   = 3'd4;

    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [3:0]  RST_EXPECTED_VERSION   = 4'h1;
    localparam logic [3:0]  RST_HIGHEST_KNOWN_TYPE = 4'hA;
    localparam logic [15:0] RST_IDENT_TYPE_MASK    = 16'h069C;
    localparam logic [15:0] RST_PAYLOAD_TYPE_MASK  = 16'h0618;
    localparam logic [15:0] RST_BUNDLE_TYPE_MASK   = 16'h0060;

    // Where the following phase is chosen from.
    typedef enum logic [1:0] {
        DONE_HEADER  = 2'd0,
        DONE_IDENT   = 2'd1,
        DONE_PAYLOAD = 2'd2
    } done_t;

endpackage

/* design/amd_in_if.sv */
// Input channel of the deframer: one received byte per request.
// Depends on nothing but the valid/ready convention.
interface amd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* design/amd_out_if.sv */
// Result channel of the deframer: one labeled byte per request.
// Uses part_t from amd_pkg.
interface amd_out_if;
    logic             valid;
    logic             ready;
    logic [7:0]       byte_out;
    amd_pkg::part_t   part;
    logic [3:0]       msg_kind;
    logic             end_of_message;
    logic [15:0]      ident_length;
    logic [63:0]      payload_length;
    logic [63:0]      bundle_number;

    modport source (output valid, output byte_out, output part, output msg_kind,
                    output end_of_message, output ident_length,
                    output payload_length, output bundle_number, input ready);
    modport sink   (input valid, input byte_out, input part, input msg_kind,
                    input end_of_message, input ident_length,
                    input payload_length, input bundle_number, output ready);
endinterface

/* design/amd_cfg_if.sv */
// Configuration write channel of the deframer: register index and data.
// Uses cfg_index_t and CFG_DATA_W from amd_pkg.
interface amd_cfg_if;
    logic                              valid;
    logic                              ready;
    amd_pkg::cfg_index_t               index;
    logic [amd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/agent_message_deframer_core.sv */
// Agent message deframer: labels each received byte within a framed message.
// Results are registered, valid in the cycle after their byte is accepted.
// Throughput: one byte per cycle while results are taken. Byte path: the
// state registers, one 64-bit decrement and zero test, the output register.
// Reset (rst_n low, asynchronous): configuration returns to its defaults, the
// parser expects a header, all counters and lengths clear, no result is held.
module agent_message_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    amd_in_if.sink     byte_ch,
    amd_out_if.source  label_ch,
    amd_cfg_if.sink    cfg
);
    import amd_pkg::*;

    typedef struct packed {
        phase_t phase;
        logic   eom;
    } adv_t;

    // Configuration registers.
    logic [3:0]  exp_ver_reg;
    logic [3:0]  max_type_reg;
    logic [15:0] id_mask_reg;
    logic [15:0] pl_mask_reg;
    logic [15:0] bn_mask_reg;

    // Parser state.
    phase_t      phase_reg,  phase_next;
    logic [3:0]  kind_reg,   kind_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [15:0] idlen_reg,  idlen_next;
    logic [63:0] rem_reg,    rem_next;
    logic [63:0] shift_reg,  shift_next;
    logic [63:0] plen_reg,   plen_next;

    // Result register.
    logic        ovalid_reg;
    logic [7:0]  obyte_reg;
    part_t       opart_reg;
    logic [3:0]  okind_reg;
    logic        oeom_reg;
    logic [15:0] oidlen_reg;
    logic [63:0] oplen_reg;
    logic [63:0] obundle_reg;

    // Combinational results for the byte being accepted.
    part_t       part_c;
    logic [3:0]  kind_c;
    logic        eom_c;
    logic [15:0] idlen_c;
    logic [63:0] plen_c;
    logic [63:0] bundle_c;

    logic [7:0]  b;
    logic [3:0]  typ;
    logic [3:0]  sel_kind;
    logic        has_id, has_pl, has_bn;
    logic        hdr_bad;
    logic [63:0] rem_dec;
    logic [2:0]  cnt_inc;
    logic [63:0] shift_in;
    logic [15:0] idlen_in;
    adv_t        adv;
    logic        accept;

    // Pick the part that follows a finished stage, in the fixed order
    // identifier, payload, bundle id. No part left means the message ends.
    function automatic adv_t advance(input done_t done, input logic hid,
                                     input logic hpl, input logic hbn);
        adv_t r;
        r.eom   = 1'b0;
        r.phase = PH_HEADER;
        if (done == DONE_HEADER && hid) begin
            r.phase = PH_IDLEN;
        end else if ((done == DONE_HEADER || done == DONE_IDENT) && hpl) begin
            r.phase = PH_PLEN;
        end else if (hbn) begin
            r.phase = PH_BUNDLE;
        end else begin
            r.eom = 1'b1;
        end
        return r;
    endfunction

    // The input side is free whenever the result register is empty or being
    // drained in this cycle; while that holds, a byte can enter every cycle.
    assign byte_ch.ready = !ovalid_reg || label_ch.ready;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign cfg.ready     = 1'b1;

    assign b        = byte_ch.data_byte;
    assign typ      = b[3:0];
    // In the header phase the new type code decides which parts follow.
    assign sel_kind = (phase_reg == PH_HEADER) ? typ : kind_reg;
    assign has_id   = id_mask_reg[sel_kind];
    assign has_pl   = pl_mask_reg[sel_kind];
    assign has_bn   = bn_mask_reg[sel_kind];
    assign hdr_bad  = (b[7:4] != exp_ver_reg) || (typ > max_type_reg);
    assign rem_dec  = (rem_reg != 64'd0) ? rem_reg - 64'd1 : rem_reg;
    assign cnt_inc  = cnt_reg + 3'd1;
    assign shift_in = {shift_reg[55:0], b};
    assign idlen_in = {idlen_reg[7:0], b};

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        idlen_next = idlen_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        plen_next  = plen_reg;
        part_c     = PART_HEADER;
        eom_c      = 1'b0;
        bundle_c   = 64'd0;
        adv        = '{phase: PH_HEADER, eom: 1'b0};
        kind_c     = kind_reg;

        case (phase_reg)
            PH_IDLEN:
            begin
                part_c     = PART_IDLEN;
                idlen_next = idlen_in;
                cnt_next   = cnt_inc;
                if (cnt_inc >= 3'd2) begin
                    if (idlen_in != 16'd0) begin
                        phase_next = PH_IDENT;
                        cnt_next   = 3'd0;
                        rem_next   = {48'd0, idlen_in};
                    end else begin
                        adv        = advance(DONE_IDENT, has_id, has_pl, has_bn);
                        phase_next = adv.phase;
                        eom_c      = adv.eom;
                        cnt_next   = 3'd0;
                        shift_next = 64'd0;
                        rem_next   = 64'd0;
                    end
                end
            end
            PH_IDENT, PH_PAYLOAD:
            begin
                part_c   = (phase_reg == PH_IDENT) ? PART_IDENT : PART_PAYLOAD;
                rem_next = rem_dec;
                if (rem_dec == 64'd0) begin
                    adv        = advance((phase_reg == PH_IDENT) ? DONE_IDENT
                                                                 : DONE_PAYLOAD,
                                         has_id, has_pl, has_bn);
                    phase_next = adv.phase;
                    eom_c      = adv.eom;
                    cnt_next   = 3'd0;
                    shift_next = 64'd0;
                end
            end
            PH_PLEN:
            begin
                part_c     = PART_PLEN;
                shift_next = shift_in;
                cnt_next   = cnt_inc;
                // The eighth length byte wraps the counter to zero.
                if (cnt_inc == 3'd0) begin
                    plen_next = shift_in;
                    if (shift_in != 64'd0) begin
                        phase_next = PH_PAYLOAD;
                        shift_next = 64'd0;
                        rem_next   = shift_in;
                    end else begin
                        adv        = advance(DONE_PAYLOAD, has_id, has_pl, has_bn);
                        phase_next = adv.phase;
                        eom_c      = adv.eom;
                        shift_next = 64'd0;
                        rem_next   = 64'd0;
                    end
                end
            end
            PH_BUNDLE:
            begin
                part_c     = PART_BUNDLE;
                shift_next = shift_in;
                cnt_next   = cnt_inc;
                if (cnt_inc == 3'd0) begin
                    bundle_c   = shift_in;
                    shift_next = 64'd0;
                    phase_next = PH_HEADER;
                    eom_c      = 1'b1;
                end
            end
            default:
            begin
                // Header byte; an unreachable phase code is handled the same.
                idlen_next = 16'd0;
                plen_next  = 64'd0;
                cnt_next   = 3'd0;
                rem_next   = 64'd0;
                shift_next = 64'd0;
                if (hdr_bad) begin
                    // Flag the byte and take the next one as a header again.
                    part_c     = PART_ERROR;
                    phase_next = PH_HEADER;
                    kind_c     = typ;
                end else begin
                    part_c     = PART_HEADER;
                    kind_next  = typ;
                    kind_c     = typ;
                    adv        = advance(DONE_HEADER, has_id, has_pl, has_bn);
                    phase_next = adv.phase;
                    eom_c      = adv.eom;
                end
            end
        endcase

        idlen_c = idlen_next;
        plen_c  = plen_next;
    end

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            exp_ver_reg  <= RST_EXPECTED_VERSION;
            max_type_reg <= RST_HIGHEST_KNOWN_TYPE;
            id_mask_reg  <= RST_IDENT_TYPE_MASK;
            pl_mask_reg  <= RST_PAYLOAD_TYPE_MASK;
            bn_mask_reg  <= RST_BUNDLE_TYPE_MASK;
        end else if (cfg.valid && cfg.ready) begin
            case (cfg.index)
                CFG_EXPECTED_VERSION:   exp_ver_reg  <= cfg.data[3:0];
                CFG_HIGHEST_KNOWN_TYPE: max_type_reg <= cfg.data[3:0];
                CFG_IDENT_TYPE_MASK:    id_mask_reg  <= cfg.data;
                CFG_PAYLOAD_TYPE_MASK:  pl_mask_reg  <= cfg.data;
                CFG_BUNDLE_TYPE_MASK:   bn_mask_reg  <= cfg.data;
                default:                ;
            endcase
        end
    end

    // Parser state advances once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HEADER;
            kind_reg  <= 4'd0;
            cnt_reg   <= 3'd0;
            idlen_reg <= 16'd0;
            rem_reg   <= 64'd0;
            shift_reg <= 64'd0;
            plen_reg  <= 64'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            idlen_reg <= idlen_next;
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
            plen_reg  <= plen_next;
        end
    end

    // Result register: holds its request until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ovalid_reg <= 1'b0;
        end else if (accept) begin
            ovalid_reg <= 1'b1;
        end else if (label_ch.ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            obyte_reg   <= b;
            opart_reg   <= part_c;
            okind_reg   <= kind_c;
            oeom_reg    <= eom_c;
            oidlen_reg  <= (part_c == PART_ERROR) ? 16'd0 : idlen_c;
            oplen_reg   <= (part_c == PART_ERROR) ? 64'd0 : plen_c;
            obundle_reg <= bundle_c;
        end
    end

    assign label_ch.valid          = ovalid_reg;
    assign label_ch.byte_out       = obyte_reg;
    assign label_ch.part           = opart_reg;
    assign label_ch.msg_kind       = okind_reg;
    assign label_ch.end_of_message = oeom_reg;
    assign label_ch.ident_length   = oidlen_reg;
    assign label_ch.payload_length = oplen_reg;
    assign label_ch.bundle_number  = obundle_reg;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for agent_message_deframer_core: feeds framed byte streams through the
// request channels and checks every labeled byte against a local predictor.
// Depends on amd_pkg and the amd_in_if, amd_out_if and amd_cfg_if interfaces.
module tb;
    import amd_pkg::*;

    // Cycles with no request taken on any channel before the run is declared hung.
    localparam int QUIET_LIMIT   = 4000;
    // Cycles left after the last label arrives, to catch stray results.
    localparam int SETTLE_CYCLES = 10;
    localparam int PRINT_LIMIT   = 200;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_OFF_CYCLES = 300;

    // Type codes used by the directed test. Under the reset masks type 0 has no
    // parts, type 2 carries only an identifier, type 3 an identifier and a payload.
    localparam logic [3:0] KIND_NO_PARTS      = 4'd0;
    localparam logic [3:0] KIND_IDENT_ONLY    = 4'd2;
    localparam logic [3:0] KIND_IDENT_PAYLOAD = 4'd3;
    localparam cfg_index_t CFG_FIRST_UNUSED   = CFG_BUNDLE_TYPE_MASK + 3'd1;

    // One predicted label, laid out like the result channel.
    typedef struct packed {
        logic [7:0]  byte_out;
        part_t       part;
        logic [3:0]  kind;
        logic        eom;
        logic [15:0] ident_len;
        logic [63:0] pay_length;
        logic [63:0] bundle;
    } label_t;

    logic clk = 1'b0;
    logic rst_n;

    amd_in_if  in_ch ();
    amd_out_if out_ch ();
    amd_cfg_if cfg_ch ();

    agent_message_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (in_ch),
        .label_ch (out_ch),
        .cfg      (cfg_ch)
    );

    always #10 clk = ~clk;

    // Predictor copy of the configuration registers.
    logic [3:0]  cfg_version;
    logic [3:0]  cfg_top_type;
    logic [15:0] mask_ident;
    logic [15:0] mask_payload;
    logic [15:0] mask_bundle;

    // Predictor copy of the parser state.
    phase_t      parse_phase;
    logic [3:0]  cur_kind;
    logic [2:0]  field_cnt;
    logic [15:0] id_len;
    logic [63:0] remaining;
    logic [63:0] shift_acc;
    logic [63:0] pay_len;

    // Labels predicted for accepted bytes, oldest first.
    label_t expected_labels[$];

    int mismatch_count;
    int quiet_cycles;
    int byte_accepts;
    int cfg_accepts;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_left;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic kind_selects(input logic [15:0] mask);
        return mask[cur_kind];
    endfunction

    // Moves on to the next part that the current type selects after the stage
    // just finished. Returns 1 when nothing follows, so the message ends here.
    function automatic logic take_next_part(input done_t done);
        field_cnt = 3'd0;
        shift_acc = 64'd0;
        remaining = 64'd0;
        if (done == DONE_HEADER && kind_selects(mask_ident)) begin
            parse_phase = PH_IDLEN;
            return 1'b0;
        end
        if (done != DONE_PAYLOAD && kind_selects(mask_payload)) begin
            parse_phase = PH_PLEN;
            return 1'b0;
        end
        if (kind_selects(mask_bundle)) begin
            parse_phase = PH_BUNDLE;
            return 1'b0;
        end
        parse_phase = PH_HEADER;
        return 1'b1;
    endfunction

    // Labels one accepted byte and advances the predicted parser state.
    function automatic label_t label_byte(input logic [7:0] b);
        label_t r;
        r = '0;
        r.byte_out = b;
        case (parse_phase)
            PH_IDLEN: begin
                r.part = PART_IDLEN;
                id_len = {id_len[7:0], b};
                field_cnt = field_cnt + 3'd1;
                if (field_cnt >= 3'd2) begin
                    if (id_len != 16'd0) begin
                        parse_phase = PH_IDENT;
                        field_cnt = 3'd0;
                        remaining = 64'(id_len);
                    end else begin
                        r.eom = take_next_part(DONE_IDENT);
                    end
                end
            end
            PH_IDENT: begin
                r.part = PART_IDENT;
                if (remaining != 64'd0) remaining = remaining - 64'd1;
                if (remaining == 64'd0) r.eom = take_next_part(DONE_IDENT);
            end
            PH_PLEN: begin
                r.part = PART_PLEN;
                shift_acc = {shift_acc[55:0], b};
                field_cnt = field_cnt + 3'd1;
                if (field_cnt == 3'd0) begin
                    pay_len = shift_acc;
                    if (pay_len != 64'd0) begin
                        parse_phase = PH_PAYLOAD;
                        shift_acc = 64'd0;
                        remaining = pay_len;
                    end else begin
                        r.eom = take_next_part(DONE_PAYLOAD);
                    end
                end
            end
            PH_PAYLOAD: begin
                r.part = PART_PAYLOAD;
                if (remaining != 64'd0) remaining = remaining - 64'd1;
                if (remaining == 64'd0) r.eom = take_next_part(DONE_PAYLOAD);
            end
            PH_BUNDLE: begin
                r.part = PART_BUNDLE;
                shift_acc = {shift_acc[55:0], b};
                field_cnt = field_cnt + 3'd1;
                if (field_cnt == 3'd0) begin
                    r.bundle = shift_acc;
                    shift_acc = 64'd0;
                    parse_phase = PH_HEADER;
                    r.eom = 1'b1;
                end
            end
            default: begin
                id_len = 16'd0;
                pay_len = 64'd0;
                // A bad version or an unknown type flags the byte and leaves the
                // parser waiting for a header; the message kind is not updated.
                if (b[7:4] != cfg_version || b[3:0] > cfg_top_type) begin
                    parse_phase = PH_HEADER;
                    field_cnt = 3'd0;
                    remaining = 64'd0;
                    shift_acc = 64'd0;
                    r.part = PART_ERROR;
                    r.kind = b[3:0];
                    return r;
                end
                r.part = PART_HEADER;
                cur_kind = b[3:0];
                r.eom = take_next_part(DONE_HEADER);
            end
        endcase
        r.kind = cur_kind;
        r.ident_len = id_len;
        r.pay_length = pay_len;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch %0d at %0t: %s got %0h, expected %0h",
                     mismatch_count, $realtime, what, got, want);
    endtask

    // Everything is sampled at the rising edge, where the inputs driven at the
    // falling edge are stable and the block's outputs still hold their old values.
    // Results are checked before the new request is predicted, so the oldest
    // label is always the one compared.
    always @(posedge clk) begin : watch_channels
        label_t want;
        logic   any_taken;
        any_taken = 1'b0;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                any_taken = 1'b1;
                cfg_accepts++;
                case (cfg_ch.index)
                    CFG_EXPECTED_VERSION:   cfg_version  = cfg_ch.data[3:0];
                    CFG_HIGHEST_KNOWN_TYPE: cfg_top_type = cfg_ch.data[3:0];
                    CFG_IDENT_TYPE_MASK:    mask_ident   = cfg_ch.data;
                    CFG_PAYLOAD_TYPE_MASK:  mask_payload = cfg_ch.data;
                    CFG_BUNDLE_TYPE_MASK:   mask_bundle  = cfg_ch.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                any_taken = 1'b1;
                if (expected_labels.size() == 0) begin
                    report_mismatch("result with no byte waiting",
                                    64'(out_ch.byte_out), 64'd0);
                end else begin
                    want = expected_labels.pop_front();
                    if (out_ch.byte_out !== want.byte_out)
                        report_mismatch("byte_out", 64'(out_ch.byte_out),
                                        64'(want.byte_out));
                    if (out_ch.part !== want.part)
                        report_mismatch("part", 64'(out_ch.part), 64'(want.part));
                    if (out_ch.msg_kind !== want.kind)
                        report_mismatch("msg_kind", 64'(out_ch.msg_kind), 64'(want.kind));
                    if (out_ch.end_of_message !== want.eom)
                        report_mismatch("end_of_message", 64'(out_ch.end_of_message),
                                        64'(want.eom));
                    if (out_ch.ident_length !== want.ident_len)
                        report_mismatch("ident_length", 64'(out_ch.ident_length),
                                        64'(want.ident_len));
                    if (out_ch.payload_length !== want.pay_length)
                        report_mismatch("payload_length", out_ch.payload_length,
                                        want.pay_length);
                    if (out_ch.bundle_number !== want.bundle)
                        report_mismatch("bundle_number", out_ch.bundle_number, want.bundle);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                any_taken = 1'b1;
                byte_accepts++;
                expected_labels.push_back(label_byte(in_ch.data_byte));
            end
            // Watchdog: a long run of cycles with no request taken anywhere
            // means the block has hung.
            if (any_taken) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Receiver: takes results at random, or holds off completely while a
    // requested hold-off is still counting down.
    always @(negedge clk) begin
        if (hold_off_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Driving. Every task below starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Offers one byte, after a random gap, and returns at the falling edge
    // that follows its acceptance. The valid stays high on return, so a
    // following byte goes out back to back.
    task automatic offer_byte(input logic [7:0] b);
        int taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        taken = byte_accepts;
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        do @(negedge clk); while (byte_accepts == taken);
    endtask

    // Sends bytes shaped by where the parser stands: mostly valid headers and
    // short lengths so that messages run through all their parts, with random
    // content and a share of random header bytes, most of them rejected.
    task automatic send_stream(input int count, input int noise_pct);
        logic [7:0] b;
        repeat (count) begin
            b = 8'($urandom_range(255));
            case (parse_phase)
                PH_HEADER:
                    if ($urandom_range(99) >= noise_pct)
                        b = {cfg_version, 4'($urandom_range(cfg_top_type))};
                // Lengths stay short so that messages finish; now and then one
                // runs past 255 to move the upper length byte.
                PH_IDLEN:
                    if (field_cnt == 3'd0) b = ($urandom_range(59) == 0) ? 8'd1 : 8'd0;
                    else b = 8'($urandom_range(6));
                PH_PLEN:
                    if (field_cnt == 3'd7) b = 8'($urandom_range(6));
                    else if (field_cnt == 3'd6 && $urandom_range(59) == 0) b = 8'd1;
                    else b = 8'd0;
                default: ;
            endcase
            offer_byte(b);
        end
    endtask

    // Stops sending and waits until every predicted label has arrived, which
    // leaves the block idle since each byte yields exactly one result.
    task automatic wait_all_labeled();
        in_ch.valid <= 1'b0;
        while (expected_labels.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        int taken;
        taken = cfg_accepts;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(negedge clk); while (cfg_accepts == taken);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] version, input logic [15:0] top_type,
                              input logic [15:0] ident, input logic [15:0] payload,
                              input logic [15:0] bundle);
        write_register(CFG_EXPECTED_VERSION, version);
        write_register(CFG_HIGHEST_KNOWN_TYPE, top_type);
        write_register(CFG_IDENT_TYPE_MASK, ident);
        write_register(CFG_PAYLOAD_TYPE_MASK, payload);
        write_register(CFG_BUNDLE_TYPE_MASK, bundle);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Byte extremes, both kinds of header error, a type with no parts, a
    // zero identifier length and a message with identifier and payload.
    task automatic test_header_cases();
        logic [7:0] bytes[$];
        bytes = {8'h00, 8'hFF, {RST_EXPECTED_VERSION, RST_HIGHEST_KNOWN_TYPE + 4'd1},
                 {RST_EXPECTED_VERSION, KIND_NO_PARTS},
                 {RST_EXPECTED_VERSION, KIND_IDENT_ONLY}, 8'h00, 8'h00,
                 {RST_EXPECTED_VERSION, KIND_IDENT_PAYLOAD}, 8'h00, 8'h01, 8'h7E,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hC3};
        foreach (bytes[i]) offer_byte(bytes[i]);
        wait_all_labeled();
    endtask

    // Writes to the indexes past the register list must change nothing.
    task automatic test_unused_indexes();
        for (int i = CFG_FIRST_UNUSED; i < (1 << $bits(cfg_index_t)); i++)
            write_register(cfg_index_t'(i), 16'($urandom));
        send_stream(60, 10);
        wait_all_labeled();
    endtask

    task automatic test_default_stream();
        send_stream(450, 10);
        wait_all_labeled();
    endtask

    // Version 0 written with the upper data bits set, every type known and
    // every type carrying all three parts.
    task automatic test_all_parts();
        set_config(16'hFFF0, 16'h000F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_stream(250, 10);
        wait_all_labeled();
    endtask

    // Version 15, only type 0 known and no type carrying any part.
    task automatic test_strict_headers();
        set_config(16'hFFFF, 16'hFFF0, 16'h0000, 16'h0000, 16'h0000);
        send_stream(120, 40);
        wait_all_labeled();
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
            send_stream(100, 15);
            wait_all_labeled();
        end
    endtask

    // Back to the reset values; the receiver holds off long enough for the
    // block to fill and push back on the sender, which keeps offering bytes.
    task automatic test_output_stall();
        set_config(16'(RST_EXPECTED_VERSION), 16'(RST_HIGHEST_KNOWN_TYPE),
                   RST_IDENT_TYPE_MASK, RST_PAYLOAD_TYPE_MASK, RST_BUNDLE_TYPE_MASK);
        hold_off_left = HOLD_OFF_CYCLES;
        send_stream(250, 10);
        wait_all_labeled();
    endtask

    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'd0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_EXPECTED_VERSION;
        cfg_ch.data = '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        byte_accepts = 0;
        cfg_accepts = 0;
        hold_off_left = 0;

        cfg_version = RST_EXPECTED_VERSION;
        cfg_top_type = RST_HIGHEST_KNOWN_TYPE;
        mask_ident = RST_IDENT_TYPE_MASK;
        mask_payload = RST_PAYLOAD_TYPE_MASK;
        mask_bundle = RST_BUNDLE_TYPE_MASK;
        parse_phase = PH_HEADER;
        cur_kind = 4'd0;
        field_cnt = 3'd0;
        id_len = 16'd0;
        remaining = 64'd0;
        shift_acc = 64'd0;
        pay_len = 64'd0;

        // Sender idles often and receiver more often for the first stretch.
        send_idle_pct = 28;
        recv_idle_pct = 65;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_header_cases();
        test_unused_indexes();
        test_default_stream();

        // Now the receiver is the eager side.
        send_idle_pct = 65;
        recv_idle_pct = 28;
        test_all_parts();
        test_strict_headers();
        test_random_settings();

        // Full rate on both sides, apart from the long hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_stall();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
design/amd_pkg.sv
design/amd_in_if.sv
design/amd_out_if.sv
design/amd_cfg_if.sv
design/agent_message_deframer_core.sv
dv/tb.sv
